>>> hw/rtl/pbc_pkg.sv
// shared types, register codes and helpers for the panic button controller
`default_nettype none

package pbc_pkg;

    localparam int unsigned CFG_INDEX_WIDTH = 4;
    localparam int unsigned CFG_DATA_WIDTH  = 16;
    localparam int unsigned TICKS_WIDTH     = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LONG_PRESS      = 4'd0,
        REG_LONG_LOCKOUT    = 4'd1,
        REG_RELEASE_LOCKOUT = 4'd2,
        REG_PAIRING_MODE    = 4'd3,
        REG_LED_ON          = 4'd4,
        REG_LED_OFF_NORMAL  = 4'd5,
        REG_LED_OFF_ALARM   = 4'd6,
        REG_BUZZER_HALF     = 4'd7
    } pbc_reg_t;

    localparam logic [TICKS_WIDTH-1:0] RST_LONG_PRESS      = 16'd1000;
    localparam logic [TICKS_WIDTH-1:0] RST_LONG_LOCKOUT    = 16'd500;
    localparam logic [TICKS_WIDTH-1:0] RST_RELEASE_LOCKOUT = 16'd100;
    localparam logic [TICKS_WIDTH-1:0] RST_LED_ON          = 16'd500;
    localparam logic [TICKS_WIDTH-1:0] RST_LED_OFF_NORMAL  = 16'd500;
    localparam logic [TICKS_WIDTH-1:0] RST_LED_OFF_ALARM   = 16'd100;
    localparam logic [TICKS_WIDTH-1:0] RST_BUZZER_HALF     = 16'd700;

    typedef struct packed {
        logic [TICKS_WIDTH-1:0] long_press_ticks;
        logic [TICKS_WIDTH-1:0] long_lockout_ticks;
        logic [TICKS_WIDTH-1:0] release_lockout_ticks;
        logic                   pairing_mode;
        logic [TICKS_WIDTH-1:0] led_on_ticks;
        logic [TICKS_WIDTH-1:0] led_off_normal_ticks;
        logic [TICKS_WIDTH-1:0] led_off_alarm_ticks;
        logic [TICKS_WIDTH-1:0] buzzer_half_ticks;
    } pbc_cfg_t;

    typedef struct packed {
        logic alarm;
        logic short_seen;
        logic long_seen;
    } pbc_button_t;

    typedef enum logic [1:0] {
        BZ_IDLE = 2'd0,
        BZ_HIGH = 2'd1,
        BZ_LOW  = 2'd2
    } pbc_bz_phase_t;

    // saturate a 16-bit tick count to the largest value of a tw-bit timer
    function automatic logic [31:0] clip_ticks(input logic [TICKS_WIDTH-1:0] v,
                                               input int unsigned tw);
        logic [32:0] tmax;
        logic [32:0] ext;
        tmax = (33'd1 << tw) - 33'd1;
        ext  = {17'd0, v};
        if (ext > tmax) begin
            return tmax[31:0];
        end
        return ext[31:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pbc_cfg.sv
// configuration register file
`default_nettype none

module pbc_cfg (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [pbc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [pbc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output pbc_pkg::pbc_cfg_t                         cfg
);
    import pbc_pkg::*;

    pbc_cfg_t cfg_reg;
    pbc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_LONG_PRESS:      cfg_next.long_press_ticks      = cfg_data;
                REG_LONG_LOCKOUT:    cfg_next.long_lockout_ticks    = cfg_data;
                REG_RELEASE_LOCKOUT: cfg_next.release_lockout_ticks = cfg_data;
                REG_PAIRING_MODE:    cfg_next.pairing_mode          = cfg_data[0];
                REG_LED_ON:          cfg_next.led_on_ticks          = cfg_data;
                REG_LED_OFF_NORMAL:  cfg_next.led_off_normal_ticks  = cfg_data;
                REG_LED_OFF_ALARM:   cfg_next.led_off_alarm_ticks   = cfg_data;
                REG_BUZZER_HALF:     cfg_next.buzzer_half_ticks     = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks      <= RST_LONG_PRESS;
            cfg_reg.long_lockout_ticks    <= RST_LONG_LOCKOUT;
            cfg_reg.release_lockout_ticks <= RST_RELEASE_LOCKOUT;
            cfg_reg.pairing_mode          <= 1'b0;
            cfg_reg.led_on_ticks          <= RST_LED_ON;
            cfg_reg.led_off_normal_ticks  <= RST_LED_OFF_NORMAL;
            cfg_reg.led_off_alarm_ticks   <= RST_LED_OFF_ALARM;
            cfg_reg.buzzer_half_ticks     <= RST_BUZZER_HALF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pbc_button.sv
// button press classifier, lockout timer and emergency latch
`default_nettype none

module pbc_button #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                tick,
    input  wire logic                button_level,
    input  pbc_pkg::pbc_cfg_t        cfg,
    output pbc_pkg::pbc_button_t     status
);
    import pbc_pkg::*;

    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    logic                   press_active_reg, press_active_next;
    logic                   long_detected_reg, long_detected_next;
    logic                   alarm_reg, alarm_next;
    logic [TIMER_WIDTH-1:0] hold_reg, hold_next;
    logic [TIMER_WIDTH-1:0] lockout_reg, lockout_next;
    logic [31:0]            long_lock_clip;
    logic [31:0]            rel_lock_clip;
    logic                   short_seen;
    logic                   long_seen;
    logic                   pressed;

    assign pressed        = !button_level;
    assign long_lock_clip = clip_ticks(cfg.long_lockout_ticks, TIMER_WIDTH);
    assign rel_lock_clip  = clip_ticks(cfg.release_lockout_ticks, TIMER_WIDTH);

    always_comb begin
        press_active_next  = press_active_reg;
        long_detected_next = long_detected_reg;
        alarm_next         = alarm_reg;
        hold_next          = hold_reg;
        lockout_next       = lockout_reg;
        short_seen         = 1'b0;
        long_seen          = 1'b0;
        if (lockout_reg != '0) begin
            lockout_next = lockout_reg - 1'b1;
        end else if (pressed) begin
            if (!press_active_reg) begin
                press_active_next = 1'b1;
                hold_next         = '0;
            end else if (hold_reg != TMAX) begin
                hold_next = hold_reg + 1'b1;
            end
            if (({{(33-TIMER_WIDTH){1'b0}}, hold_next} > {17'd0, cfg.long_press_ticks})
                && !long_detected_reg) begin
                long_detected_next = 1'b1;
                long_seen          = 1'b1;
                alarm_next         = 1'b0;
                lockout_next       = long_lock_clip[TIMER_WIDTH-1:0];
            end
        end else if (press_active_reg) begin
            if (long_detected_reg) begin
                long_detected_next = 1'b0;
            end else begin
                short_seen = 1'b1;
                if (!cfg.pairing_mode) begin
                    alarm_next = 1'b1;
                end
            end
            lockout_next      = rel_lock_clip[TIMER_WIDTH-1:0];
            press_active_next = 1'b0;
        end
    end

    assign status.alarm      = alarm_next;
    assign status.short_seen = short_seen;
    assign status.long_seen  = long_seen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_active_reg  <= 1'b0;
            long_detected_reg <= 1'b0;
            alarm_reg         <= 1'b0;
            hold_reg          <= '0;
            lockout_reg       <= '0;
        end else if (tick) begin
            press_active_reg  <= press_active_next;
            long_detected_reg <= long_detected_next;
            alarm_reg         <= alarm_next;
            hold_reg          <= hold_next;
            lockout_reg       <= lockout_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pbc_indicator.sv
// led blinker and buzzer sequencer
`default_nettype none

module pbc_indicator #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          tick,
    input  wire logic          alarm,
    input  pbc_pkg::pbc_cfg_t  cfg,
    output logic               led_pin,
    output logic               buzzer_pin
);
    import pbc_pkg::*;

    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    logic                   led_off_reg, led_off_next;
    logic [TIMER_WIDTH-1:0] led_timer_reg, led_timer_next;
    logic [TIMER_WIDTH-1:0] led_bump;
    logic [15:0]            led_dur;
    logic [31:0]            led_dur_clip;

    pbc_bz_phase_t          bz_phase_reg, bz_phase_next, bz_phase_cur;
    logic [TIMER_WIDTH-1:0] bz_timer_reg, bz_timer_next, bz_timer_cur;
    logic [TIMER_WIDTH-1:0] bz_bump;
    logic [31:0]            bz_half_clip;

    // led
    always_comb begin
        if (led_off_reg) begin
            led_dur = alarm ? cfg.led_off_alarm_ticks : cfg.led_off_normal_ticks;
        end else begin
            led_dur = cfg.led_on_ticks;
        end
        led_dur_clip   = clip_ticks(led_dur, TIMER_WIDTH);
        led_bump       = (led_timer_reg == TMAX) ? TMAX : led_timer_reg + 1'b1;
        led_off_next   = led_off_reg;
        led_timer_next = led_bump;
        if (led_bump >= led_dur_clip[TIMER_WIDTH-1:0]) begin
            led_off_next   = !led_off_reg;
            led_timer_next = '0;
        end
    end

    assign led_pin = led_off_reg;

    // buzzer next state
    assign bz_half_clip = clip_ticks(cfg.buzzer_half_ticks, TIMER_WIDTH);

    always_comb begin
        bz_phase_cur = bz_phase_reg;
        bz_timer_cur = bz_timer_reg;
        unique case (bz_phase_reg)
            BZ_HIGH, BZ_LOW: bz_phase_cur = bz_phase_reg;
            default: begin
                bz_phase_cur = BZ_IDLE;
                if (alarm) begin
                    bz_phase_cur = BZ_HIGH;
                    bz_timer_cur = '0;
                end
            end
        endcase
        bz_bump       = (bz_timer_cur == TMAX) ? TMAX : bz_timer_cur + 1'b1;
        bz_phase_next = bz_phase_cur;
        bz_timer_next = bz_timer_cur;
        if (bz_phase_cur != BZ_IDLE) begin
            bz_timer_next = bz_bump;
            if (bz_bump >= bz_half_clip[TIMER_WIDTH-1:0]) begin
                bz_timer_next = '0;
                if (bz_phase_cur == BZ_HIGH) begin
                    bz_phase_next = BZ_LOW;
                end else begin
                    bz_phase_next = alarm ? BZ_HIGH : BZ_IDLE;
                end
            end
        end
    end

    // buzzer output
    always_comb begin
        buzzer_pin = (bz_phase_cur == BZ_HIGH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_off_reg   <= 1'b0;
            led_timer_reg <= '0;
            bz_phase_reg  <= BZ_IDLE;
            bz_timer_reg  <= '0;
        end else if (tick) begin
            led_off_reg   <= led_off_next;
            led_timer_reg <= led_timer_next;
            bz_phase_reg  <= bz_phase_next;
            bz_timer_reg  <= bz_timer_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/panic_button_controller.sv
// panic button controller top level with result register
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata[0] button_level
//  m_        out        m_tvalid / m_tready  m_tdata[4:0] result fields
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one tick item per cycle; its result appears in the result register on the
// next cycle, from one pass of counter and compare logic over the state.
// the state registers and the result valid flag clear on reset, the config
// registers load their defaults. a held result stalls input only while
// m_tready is low with a result waiting; cfg_ready is always high.
`default_nettype none

module panic_button_controller #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [0] button_level
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,   // [0] emergency, [1] led_pin,
                                                                // [2] buzzer_pin,
                                                                // [3] short_press_seen,
                                                                // [4] long_press_seen
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pbc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [pbc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import pbc_pkg::*;

    pbc_cfg_t    cfg;
    pbc_button_t status;
    logic        tick;
    logic        led_pin;
    logic        buzzer_pin;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign tick     = s_tvalid && s_tready;

    pbc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbc_button #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_button (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (tick),
        .button_level (s_tdata[0]),
        .cfg          (cfg),
        .status       (status)
    );

    pbc_indicator #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_indicator (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (tick),
        .alarm      (status.alarm),
        .cfg        (cfg),
        .led_pin    (led_pin),
        .buzzer_pin (buzzer_pin)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (tick) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            m_tdata_reg <= {3'b000, status.long_seen, status.short_seen,
                            buzzer_pin, led_pin, status.alarm};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> tb/pbc_checker.sv
// result checker for the panic button controller: predicts each tick's outputs and compares
module pbc_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic [7:0]                          s_tdata,   // [0] button_level
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [7:0]                          m_tdata,   // [0] emergency, [1] led_pin,
                                                                // [2] buzzer_pin,
                                                                // [3] short_press_seen,
                                                                // [4] long_press_seen
    input  wire logic                                cfg_valid,
    input  wire logic                                cfg_ready,
    input  wire logic [pbc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [pbc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                                       mismatch_count,
    output int                                       outputs_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import pbc_pkg::*;

    typedef logic [TICKS_WIDTH-1:0] ticks_t;

    typedef struct packed {
        logic long_press_seen;
        logic short_press_seen;
        logic buzzer_pin;
        logic led_pin;
        logic emergency;
    } tick_result_t;

    localparam int RESULT_FIELDS = 5;

    string field_names[RESULT_FIELDS] = '{"emergency", "led_pin", "buzzer_pin",
                                          "short_press_seen", "long_press_seen"};

    pbc_cfg_t      settings;
    logic          button_down;
    logic          long_held;
    ticks_t        hold_count;
    ticks_t        lockout_left;
    logic          alarm_on;
    logic          led_high;
    ticks_t        led_count;
    pbc_bz_phase_t bz_phase;
    ticks_t        bz_count;

    tick_result_t  pending_outputs[$];
    tick_result_t  want;
    tick_result_t  got;
    int            results_seen;

    function automatic ticks_t sat_inc(input ticks_t v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // advances the block's state by one tick and returns that tick's outputs
    function automatic tick_result_t next_tick_outputs(input logic level);
        tick_result_t r;
        ticks_t       dur;
        r = '0;

        if (lockout_left != '0) begin
            lockout_left = lockout_left - 1'b1;
        end else if (!level) begin
            if (!button_down) begin
                button_down = 1'b1;
                hold_count  = '0;
            end else begin
                hold_count = sat_inc(hold_count);
            end
            if (hold_count > settings.long_press_ticks && !long_held) begin
                long_held         = 1'b1;
                r.long_press_seen = 1'b1;
                alarm_on          = 1'b0;
                lockout_left      = settings.long_lockout_ticks;
            end
        end else if (button_down) begin
            if (long_held) begin
                long_held = 1'b0;
            end else begin
                r.short_press_seen = 1'b1;
                if (!settings.pairing_mode) begin
                    alarm_on = 1'b1;
                end
            end
            lockout_left = settings.release_lockout_ticks;
            button_down  = 1'b0;
        end

        r.led_pin = led_high;
        if (led_high) begin
            dur = alarm_on ? settings.led_off_alarm_ticks : settings.led_off_normal_ticks;
        end else begin
            dur = settings.led_on_ticks;
        end
        led_count = sat_inc(led_count);
        if (led_count >= dur) begin
            led_high  = !led_high;
            led_count = '0;
        end

        if (bz_phase != BZ_HIGH && bz_phase != BZ_LOW) begin
            bz_phase = BZ_IDLE;
            if (alarm_on) begin
                bz_phase = BZ_HIGH;
                bz_count = '0;
            end
        end
        r.buzzer_pin = (bz_phase == BZ_HIGH);
        if (bz_phase != BZ_IDLE) begin
            bz_count = sat_inc(bz_count);
            if (bz_count >= settings.buzzer_half_ticks) begin
                bz_count = '0;
                if (bz_phase == BZ_HIGH) begin
                    bz_phase = BZ_LOW;
                end else begin
                    bz_phase = alarm_on ? BZ_HIGH : BZ_IDLE;
                end
            end
        end

        r.emergency = alarm_on;
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("pbc_checker: %s", msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            settings.long_press_ticks      = RST_LONG_PRESS;
            settings.long_lockout_ticks    = RST_LONG_LOCKOUT;
            settings.release_lockout_ticks = RST_RELEASE_LOCKOUT;
            settings.pairing_mode          = 1'b0;
            settings.led_on_ticks          = RST_LED_ON;
            settings.led_off_normal_ticks  = RST_LED_OFF_NORMAL;
            settings.led_off_alarm_ticks   = RST_LED_OFF_ALARM;
            settings.buzzer_half_ticks     = RST_BUZZER_HALF;
            button_down  = 1'b0;
            long_held    = 1'b0;
            hold_count   = '0;
            lockout_left = '0;
            alarm_on     = 1'b0;
            led_high     = 1'b0;
            led_count    = '0;
            bz_phase     = BZ_IDLE;
            bz_count     = '0;
            pending_outputs.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LONG_PRESS:      settings.long_press_ticks      = cfg_data;
                    REG_LONG_LOCKOUT:    settings.long_lockout_ticks    = cfg_data;
                    REG_RELEASE_LOCKOUT: settings.release_lockout_ticks = cfg_data;
                    REG_PAIRING_MODE:    settings.pairing_mode          = cfg_data[0];
                    REG_LED_ON:          settings.led_on_ticks          = cfg_data;
                    REG_LED_OFF_NORMAL:  settings.led_off_normal_ticks  = cfg_data;
                    REG_LED_OFF_ALARM:   settings.led_off_alarm_ticks   = cfg_data;
                    REG_BUZZER_HALF:     settings.buzzer_half_ticks     = cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got = tick_result_t'(m_tdata[RESULT_FIELDS-1:0]);
                if (pending_outputs.size() == 0) begin
                    report_error($sformatf("result %0d arrived with no tick waiting",
                                           results_seen));
                end else begin
                    want = pending_outputs.pop_front();
                    for (int i = 0; i < RESULT_FIELDS; i++) begin
                        if (got[i] !== want[i]) begin
                            report_error($sformatf("result %0d: %s is %b, expected %b",
                                                   results_seen, field_names[i],
                                                   got[i], want[i]));
                        end
                    end
                end
                results_seen++;
            end

            if (s_tvalid && s_tready) begin
                pending_outputs.push_back(next_tick_outputs(s_tdata[0]));
            end
        end
        outputs_owed = pending_outputs.size();
    end

endmodule

>>> tb/testbench.sv
// top of the panic button controller testbench: clock, reset, tick stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 16;
    localparam int PHASE_ITEMS    = 72;
    localparam int LAST_ITEMS     = 60;
    localparam logic RELEASED     = 1'b1;
    localparam logic PRESSED      = 1'b0;

    typedef enum int {SET_SMALL, SET_FLOOR, SET_CEILING, SET_WIDE} setting_kind_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata   = '0;   // [0] button_level
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [7:0]                 m_tdata;          // [0] emergency, [1] led_pin, [2] buzzer_pin,
                                                  // [3] short_press_seen, [4] long_press_seen
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_LONG_PRESS;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    int       fail_count;
    int       owed;
    int       idle_cycles = 0;
    int       sink_wait   = 0;
    int       ticks_sent  = 0;
    bit       src_idle    = 1'b1;
    bit       sink_idle   = 1'b1;
    pbc_cfg_t plan;

    always #1 aclk = ~aclk;

    panic_button_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pbc_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (fail_count),
        .outputs_owed   (owed)
    );

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int clamp(input int v, input int hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic pbc_cfg_t pick_settings(input setting_kind_t kind);
        pbc_cfg_t c;
        c.long_press_ticks      = TICKS_WIDTH'($urandom_range(1, 30));
        c.long_lockout_ticks    = TICKS_WIDTH'($urandom_range(0, 40));
        c.release_lockout_ticks = TICKS_WIDTH'($urandom_range(0, 40));
        c.pairing_mode          = ($urandom_range(0, 2) == 0);
        c.led_on_ticks          = TICKS_WIDTH'($urandom_range(1, 20));
        c.led_off_normal_ticks  = TICKS_WIDTH'($urandom_range(1, 20));
        c.led_off_alarm_ticks   = TICKS_WIDTH'($urandom_range(1, 20));
        c.buzzer_half_ticks     = TICKS_WIDTH'($urandom_range(1, 20));
        case (kind)
            SET_FLOOR: begin
                c.long_press_ticks      = 16'd1;
                c.long_lockout_ticks    = '0;
                c.release_lockout_ticks = '0;
                c.led_on_ticks          = 16'd1;
                c.led_off_normal_ticks  = 16'd1;
                c.led_off_alarm_ticks   = 16'd1;
                c.buzzer_half_ticks     = 16'd1;
            end
            SET_CEILING: begin
                c.long_press_ticks      = '1;
                c.release_lockout_ticks = TICKS_WIDTH'($urandom_range(0, 20));
                c.led_on_ticks          = '1;
                c.led_off_normal_ticks  = '1;
                c.led_off_alarm_ticks   = '1;
                c.buzzer_half_ticks     = '1;
            end
            SET_WIDE: begin
                c.led_on_ticks          = TICKS_WIDTH'($urandom_range(1, 65535));
                c.led_off_normal_ticks  = TICKS_WIDTH'($urandom_range(1, 65535));
                c.led_off_alarm_ticks   = TICKS_WIDTH'($urandom_range(1, 65535));
                c.buzzer_half_ticks     = TICKS_WIDTH'($urandom_range(1, 65535));
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_tick(input logic level);
        int gap;
        gap = pick_gap(src_idle);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, level};
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
    endtask

    task automatic send_run(input logic level, input int count);
        repeat (count) send_tick(level);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // writes every register, then one random index beyond the register list
    task automatic load_settings(input pbc_cfg_t c);
        write_reg(REG_LONG_PRESS,      c.long_press_ticks);
        write_reg(REG_LONG_LOCKOUT,    c.long_lockout_ticks);
        write_reg(REG_RELEASE_LOCKOUT, c.release_lockout_ticks);
        write_reg(REG_PAIRING_MODE,    {15'($urandom_range(0, 32767)), c.pairing_mode});
        write_reg(REG_LED_ON,          c.led_on_ticks);
        write_reg(REG_LED_OFF_NORMAL,  c.led_off_normal_ticks);
        write_reg(REG_LED_OFF_ALARM,   c.led_off_alarm_ticks);
        write_reg(REG_BUZZER_HALF,     c.buzzer_half_ticks);
        write_reg(CFG_INDEX_WIDTH'(REG_BUZZER_HALF) + CFG_INDEX_WIDTH'($urandom_range(1, 8)),
                  CFG_DATA_WIDTH'($urandom_range(0, 65535)));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (owed != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    // one press then release, sized around the long-press threshold, or a burst of noise
    task automatic send_press_pattern(input pbc_cfg_t c);
        int reach;
        int n_press;
        int n_release;
        reach = clamp(int'(c.long_press_ticks), 40);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
        end else begin
            if ($urandom_range(0, 9) < 6) begin
                n_press = $urandom_range(1, reach + 1);
            end else begin
                n_press = $urandom_range(reach + 2,
                                         reach + clamp(int'(c.long_lockout_ticks), 60) + 10);
            end
            n_release = $urandom_range(1, clamp(int'(c.release_lockout_ticks), 60) + 4);
            send_run(PRESSED, n_press);
            send_run(RELEASED, n_release);
        end
    endtask

    always @(negedge aclk) begin
        if (sink_wait != 0) begin
            m_tready  <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else begin
            m_tready  <= 1'b1;
            sink_wait <= pick_gap(sink_idle);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int sent;
        setting_kind_t kind;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings in force
        send_run(RELEASED, 3);
        send_run(PRESSED, 2);
        send_run(RELEASED, 1);
        drain();

        // short press raises the alarm, long press clears it through its lockout
        plan = pick_settings(SET_SMALL);
        plan.long_press_ticks      = 16'd3;
        plan.long_lockout_ticks    = 16'd2;
        plan.release_lockout_ticks = '0;
        plan.pairing_mode          = 1'b0;
        plan.led_on_ticks          = 16'd1;
        plan.led_off_normal_ticks  = 16'd1;
        plan.led_off_alarm_ticks   = 16'd2;
        plan.buzzer_half_ticks     = 16'd1;
        load_settings(plan);
        send_run(RELEASED, 1);
        send_run(PRESSED, 2);
        send_run(RELEASED, 2);
        send_run(PRESSED, 8);
        send_run(RELEASED, 1);
        send_run(PRESSED, 1);
        send_run(RELEASED, 1);
        drain();

        // pairing mode: short press is seen but leaves the alarm off
        plan.pairing_mode = 1'b1;
        load_settings(plan);
        send_run(PRESSED, 5);
        send_run(RELEASED, 3);
        send_run(PRESSED, 1);
        send_run(RELEASED, 2);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                1:       kind = SET_FLOOR;
                2:       kind = SET_CEILING;
                default: kind = ($urandom_range(0, 3) == 0) ? SET_WIDE : SET_SMALL;
            endcase
            plan = pick_settings(kind);
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            load_settings(plan);
            sent = ticks_sent;
            while (ticks_sent - sent < PHASE_ITEMS) begin
                send_press_pattern(plan);
            end
            drain();
        end

        // longest lockouts last, since they freeze sampling for the rest of the run
        plan = pick_settings(SET_SMALL);
        plan.long_lockout_ticks    = '1;
        plan.release_lockout_ticks = '1;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        load_settings(plan);
        sent = ticks_sent;
        while (ticks_sent - sent < LAST_ITEMS) begin
            send_press_pattern(plan);
        end
        drain();

        repeat (4) @(negedge aclk);
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
